FILE: hdl/icsum_pkg.sv
// ----------------------------------------------------------------------------
// icsum_pkg: shared types and helpers for the internet checksum engine
// Holds the input beat record, the operation and message-kind codes, the
// status codes and the one's complement add used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package icsum_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_IP   = 2'd0,
        KIND_ICMP = 2'd1,
        KIND_TCP  = 2'd2,
        KIND_UDP  = 2'd3
    } t_kind;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    typedef struct packed {
        t_op         operation;
        t_kind       message_kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol_number;
        logic [15:0] total_length;
        logic [15:0] data_word;
        logic        zero_word;
    } t_item;

    // One's complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ip_icmp_tcp_udp_checksum_top.sv
// ----------------------------------------------------------------------------
// ip_icmp_tcp_udp_checksum_top: internet checksum offload engine
// Computes the one's complement checksum of IP headers, ICMP, TCP and UDP
// messages from a stream of start and 16-bit data beats.
// ----------------------------------------------------------------------------
// The block accepts one input beat every clock cycle, start beats and data
// beats alike, except while a held result is stalled on the output side.
// The beat that closes a message is held in the input register, and its
// result is then registered in the result register. The running sum is
// updated combinationally from the held beat: a 16-bit add with end-around
// carry, and on a start beat a six-word pseudo-header sum with a double
// fold, both between the input register and the state and result
// registers. A start beat gives the message kind and the IP header fields;
// for TCP and UDP the pseudo-header (source, destination, protocol and
// payload length, which is total length minus the IP header size) is added
// at once. Data beats then carry big-endian words until the byte count is
// used up: the header size for the IP header kind, the payload length for
// the others. A word flagged as the checksum field counts as zero and an
// odd last byte is padded with zero. A start beat whose total length is
// shorter than the IP header yields a result at once with checksum zero and
// status one. ICMP, TCP or UDP with an empty payload yield their result on
// the start beat. Data beats outside a message are dropped, and a start
// beat in the middle of a message abandons that message.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_icmp_tcp_udp_checksum_top #(
    parameter int IP_HEADER_BYTES = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [1:0]  i_message_kind,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [15:0] i_total_length,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_zero_word,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_checksum,
    output logic             o_status
);

    icsum_pkg::t_item in_item;
    icsum_pkg::t_item held_item;
    logic             held_valid;
    logic             take;

    // Gather the beat fields into one record for the input register.
    always_comb begin
        in_item.operation       = icsum_pkg::t_op'(i_operation);
        in_item.message_kind    = icsum_pkg::t_kind'(i_message_kind);
        in_item.src_addr        = i_src_addr;
        in_item.dst_addr        = i_dst_addr;
        in_item.protocol_number = i_protocol_number;
        in_item.total_length    = i_total_length;
        in_item.data_word       = i_data_word;
        in_item.zero_word       = i_zero_word;
    end

    icsum_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    icsum_engine #(
        .IP_HEADER_BYTES (IP_HEADER_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_checksum  (o_checksum),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

FILE: hdl/icsum_in_stage.sv
// ----------------------------------------------------------------------------
// icsum_in_stage: input register
// Captures one beat and holds it until the engine takes it; a new beat is
// accepted in the same cycle that the held one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_in_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire icsum_pkg::t_item i_item,
    output logic                  o_valid,
    output icsum_pkg::t_item      o_item,
    input  wire logic             i_take
);

    logic             r_valid;
    icsum_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/icsum_engine.sv
// ----------------------------------------------------------------------------
// icsum_engine: checksum state, combinational update and result register
// Adds the pseudo-header on a start beat, folds each data word into the
// running sum and registers the complemented sum when the message ends.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_engine #(
    parameter int IP_HEADER_BYTES = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire icsum_pkg::t_item i_item,
    output logic                  o_take,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [15:0]           o_checksum,
    output logic                  o_status
);

    localparam logic [15:0] HDR_BYTES = 16'(IP_HEADER_BYTES);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_left, n_left;
    logic        r_active, n_active;

    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic        r_status;

    logic        res_valid;
    logic [15:0] res_checksum;
    logic        res_status;

    logic [15:0] plen;
    logic [18:0] pseudo_wide;
    logic [16:0] pseudo_fold;
    logic [15:0] pseudo_sum;
    logic [15:0] start_sum;
    logic [15:0] word;
    logic [15:0] data_sum;

    // The engine moves only when the result register can take a beat.
    assign o_take = i_valid && (!r_out_valid || i_out_ready);

    assign plen = i_item.total_length - HDR_BYTES;

    // Pseudo-header: both addresses as word pairs, protocol, payload length.
    assign pseudo_wide = 19'(i_item.src_addr[31:16]) + 19'(i_item.src_addr[15:0])
                       + 19'(i_item.dst_addr[31:16]) + 19'(i_item.dst_addr[15:0])
                       + 19'(i_item.protocol_number) + 19'(plen);
    assign pseudo_fold = 17'(pseudo_wide[15:0]) + 17'(pseudo_wide[18:16]);
    assign pseudo_sum  = pseudo_fold[15:0] + {15'd0, pseudo_fold[16]};

    assign start_sum = (i_item.message_kind == icsum_pkg::KIND_TCP ||
                        i_item.message_kind == icsum_pkg::KIND_UDP) ? pseudo_sum : 16'd0;

    // The checksum field counts as zero, and an odd last byte is padded.
    always_comb begin
        word = i_item.zero_word ? 16'd0 : i_item.data_word;
        if (r_left == 16'd1) begin
            word = {word[15:8], 8'd0};
        end
    end

    assign data_sum = icsum_pkg::add_ones(r_sum, word);

    always_comb begin
        n_sum        = r_sum;
        n_left       = r_left;
        n_active     = r_active;
        res_valid    = 1'b0;
        res_checksum = 16'd0;
        res_status   = icsum_pkg::STATUS_OK;
        unique case (i_item.operation)
            icsum_pkg::OP_START: begin
                n_sum    = 16'd0;
                n_left   = 16'd0;
                n_active = 1'b0;
                if (i_item.total_length < HDR_BYTES) begin
                    res_valid  = 1'b1;
                    res_status = icsum_pkg::STATUS_SHORT;
                end else if (i_item.message_kind == icsum_pkg::KIND_IP) begin
                    n_left   = HDR_BYTES;
                    n_active = 1'b1;
                end else if (plen == 16'd0) begin
                    res_valid    = 1'b1;
                    res_checksum = ~start_sum;
                end else begin
                    n_sum    = start_sum;
                    n_left   = plen;
                    n_active = 1'b1;
                end
            end
            icsum_pkg::OP_DATA: begin
                if (r_active) begin
                    n_sum = data_sum;
                    if (r_left <= 16'd2) begin
                        n_left       = 16'd0;
                        n_active     = 1'b0;
                        res_valid    = 1'b1;
                        res_checksum = ~data_sum;
                    end else begin
                        n_left = r_left - 16'd2;
                    end
                end
            end
            default: begin
                n_sum = r_sum;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= 16'd0;
            r_left   <= 16'd0;
            r_active <= 1'b0;
        end else if (o_take) begin
            r_sum    <= n_sum;
            r_left   <= n_left;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && res_valid) begin
            r_checksum <= res_checksum;
            r_status   <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;
    assign o_status    = r_status;

endmodule

`default_nettype wire

FILE: hdl/icsum_checker.sv
// ----------------------------------------------------------------------------
// icsum_checker: port-level assertions for the checksum engine
// Watches the top level's channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icsum_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_checksum,
    input wire logic        o_status
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_checksum) && $stable(o_status)))
        else $error("result beat changed while stalled");

    // An error result always carries a zero checksum.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == icsum_pkg::STATUS_SHORT) |-> (o_checksum == 16'd0))
        else $error("error result with nonzero checksum");

    // With the result register empty, the input side never stalls.
    a_ready_free: assert property (@(posedge i_clk)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // A fresh result follows an accepted beat through both registers.
    a_rise_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result appeared without a beat two cycles earlier");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind ip_icmp_tcp_udp_checksum_top icsum_checker u_icsum_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_checksum  (o_checksum),
    .o_status    (o_status)
);

`default_nettype wire

FILE: dv/icsum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icsum_scoreboard: result predictor and scoreboard for the checksum engine
// Watches both channels, works out the checksum that every accepted input
// beat leads to, and compares each accepted result beat with the oldest one.
// ----------------------------------------------------------------------------
module icsum_scoreboard #(
    parameter int HDR_BYTES = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_operation,
    input  wire logic [1:0]  i_message_kind,
    input  wire logic [31:0] i_src_addr,
    input  wire logic [31:0] i_dst_addr,
    input  wire logic [7:0]  i_protocol_number,
    input  wire logic [15:0] i_total_length,
    input  wire logic [15:0] i_data_word,
    input  wire logic        i_zero_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_checksum,
    input  wire logic        i_status,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [15:0] checksum;
        logic        status;
    } t_csum_result;

    logic [15:0]  sum_acc    = '0;
    logic [15:0]  bytes_owed = '0;
    logic         msg_open   = 1'b0;
    t_csum_result checksums_due[$];
    int           mismatches = 0;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    function automatic t_csum_result closing_result(input logic [15:0] s);
        return '{checksum: ~s, status: icsum_pkg::STATUS_OK};
    endfunction

    // Updates the running sum for one accepted input beat and queues the
    // checksum when the beat closes a message.
    task automatic advance_checksum();
        logic [15:0] payload_len;
        logic [15:0] word;
        if (icsum_pkg::t_op'(i_operation) == icsum_pkg::OP_START) begin
            sum_acc    = '0;
            bytes_owed = '0;
            msg_open   = 1'b0;
            if (i_total_length < HDR_BYTES) begin
                checksums_due.push_back('{checksum: 16'h0000,
                                          status: icsum_pkg::STATUS_SHORT});
            end else begin
                payload_len = i_total_length - 16'(HDR_BYTES);
                if (icsum_pkg::t_kind'(i_message_kind) == icsum_pkg::KIND_IP) begin
                    bytes_owed = 16'(HDR_BYTES);
                    msg_open   = 1'b1;
                end else begin
                    if (icsum_pkg::t_kind'(i_message_kind) == icsum_pkg::KIND_TCP ||
                        icsum_pkg::t_kind'(i_message_kind) == icsum_pkg::KIND_UDP) begin
                        // Pseudo-header: addresses, zero byte plus protocol, length.
                        sum_acc = ones_add(sum_acc, i_src_addr[31:16]);
                        sum_acc = ones_add(sum_acc, i_src_addr[15:0]);
                        sum_acc = ones_add(sum_acc, i_dst_addr[31:16]);
                        sum_acc = ones_add(sum_acc, i_dst_addr[15:0]);
                        sum_acc = ones_add(sum_acc, {8'h00, i_protocol_number});
                        sum_acc = ones_add(sum_acc, payload_len);
                    end
                    if (payload_len == 16'd0) begin
                        checksums_due.push_back(closing_result(sum_acc));
                    end else begin
                        bytes_owed = payload_len;
                        msg_open   = 1'b1;
                    end
                end
            end
        end else if (msg_open) begin
            word = i_zero_word ? 16'h0000 : i_data_word;
            if (bytes_owed == 16'd1) begin
                word[7:0] = 8'h00;
            end
            sum_acc = ones_add(sum_acc, word);
            if (bytes_owed <= 16'd2) begin
                checksums_due.push_back(closing_result(sum_acc));
                msg_open   = 1'b0;
                bytes_owed = '0;
            end else begin
                bytes_owed = bytes_owed - 16'd2;
            end
        end
    endtask

    task automatic compare_result();
        t_csum_result want;
        if (checksums_due.size() == 0) begin
            $display("%0t: result beat with nothing expected, got checksum %h status %b",
                     $time, i_checksum, i_status);
            mismatches++;
        end else begin
            want = checksums_due.pop_front();
            if (i_checksum !== want.checksum || i_status !== want.status) begin
                $display("%0t: result mismatch, expected checksum %h status %b, got %h %b",
                         $time, want.checksum, want.status, i_checksum, i_status);
                mismatches++;
            end
        end
    endtask

    // A result leaves only after its closing beat has passed both registers,
    // so the output side is checked before this edge's input beat is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sum_acc    = '0;
            bytes_owed = '0;
            msg_open   = 1'b0;
            checksums_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_result();
            end
            if (i_in_valid && i_in_ready) begin
                advance_checksum();
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= checksums_due.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the internet checksum engine
// Drives start and data beats into the engine with random gaps, throttles
// the result side, and reports the outcome of the checker placed beside it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HDR_BYTES       = 20;
    localparam int RANDOM_BEATS    = 750;
    // The result side holds off once, after this many counted beats, for
    // long enough that the engine fills up and pushes back on the input.
    localparam int HOLD_AT_BEAT    = 200;
    localparam int HOLD_OFF_CYCLES = 150;
    // Counted-beat window in which neither side idles at all.
    localparam int CALM_FROM       = 450;
    localparam int CALM_TO         = 600;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             out_ready = 1'b0;
    icsum_pkg::t_item in_beat   = '0;
    logic             in_ready;
    logic             out_valid;
    logic [15:0]      checksum;
    logic             status;
    int               fail_count;
    int               pending;

    // Beats that the engine acts on; stray data beats outside a message are
    // left out of the count.
    int          beats_sent = 0;
    bit          holding    = 1'b0;
    bit          held_once  = 1'b0;

    // 4 ns clock period.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ip_icmp_tcp_udp_checksum_top #(
        .IP_HEADER_BYTES(HDR_BYTES)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (in_beat.operation),
        .i_message_kind   (in_beat.message_kind),
        .i_src_addr       (in_beat.src_addr),
        .i_dst_addr       (in_beat.dst_addr),
        .i_protocol_number(in_beat.protocol_number),
        .i_total_length   (in_beat.total_length),
        .i_data_word      (in_beat.data_word),
        .i_zero_word      (in_beat.zero_word),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_checksum       (checksum),
        .o_status         (status)
    );

    icsum_scoreboard #(
        .HDR_BYTES(HDR_BYTES)
    ) u_scoreboard (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_operation      (in_beat.operation),
        .i_message_kind   (in_beat.message_kind),
        .i_src_addr       (in_beat.src_addr),
        .i_dst_addr       (in_beat.dst_addr),
        .i_protocol_number(in_beat.protocol_number),
        .i_total_length   (in_beat.total_length),
        .i_data_word      (in_beat.data_word),
        .i_zero_word      (in_beat.zero_word),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_checksum       (checksum),
        .i_status         (status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic bit calm_stretch();
        return beats_sent >= CALM_FROM && beats_sent < CALM_TO;
    endfunction

    // Every field random: the fields that the operation does not use stay
    // random in every beat, so the engine has to ignore them.
    function automatic icsum_pkg::t_item scrambled();
        icsum_pkg::t_item b;
        b.operation       = icsum_pkg::t_op'($urandom_range(1));
        b.message_kind    = icsum_pkg::t_kind'($urandom_range(3));
        b.src_addr        = $urandom;
        b.dst_addr        = $urandom;
        b.protocol_number = 8'($urandom);
        b.total_length    = 16'($urandom);
        b.data_word       = 16'($urandom);
        b.zero_word       = 1'($urandom);
        return b;
    endfunction

    function automatic icsum_pkg::t_item start_of(input icsum_pkg::t_kind k,
                                                  input logic [15:0] tlen,
                                                  input logic [31:0] src,
                                                  input logic [31:0] dst,
                                                  input logic [7:0] proto);
        icsum_pkg::t_item b;
        b                 = scrambled();
        b.operation       = icsum_pkg::OP_START;
        b.message_kind    = k;
        b.total_length    = tlen;
        b.src_addr        = src;
        b.dst_addr        = dst;
        b.protocol_number = proto;
        return b;
    endfunction

    function automatic icsum_pkg::t_item word_of(input logic [15:0] w, input logic z);
        icsum_pkg::t_item b;
        b           = scrambled();
        b.operation = icsum_pkg::OP_DATA;
        b.data_word = w;
        b.zero_word = z;
        return b;
    endfunction

    // Number of data beats that close a message of this kind and length.
    function automatic int beats_needed(input icsum_pkg::t_kind k, input int tlen);
        if (tlen < HDR_BYTES) begin
            return 0;
        end
        if (k == icsum_pkg::KIND_IP) begin
            return HDR_BYTES / 2;
        end
        return (tlen - HDR_BYTES + 1) / 2;
    endfunction

    // Offers one beat from a falling edge and holds it until the rising edge
    // at which it is taken. Afterwards valid may drop for some cycles, each
    // idle cycle drawn on its own. A beat that follows without a gap keeps
    // valid high, so valid gets only one assignment per falling edge.
    task automatic send_beat(input icsum_pkg::t_item b, input bit counted);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        if (counted) begin
            beats_sent++;
        end
        @(negedge clk);
        while (!holding && !calm_stretch() && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            in_beat  <= scrambled();
            @(negedge clk);
        end
    endtask

    // A start beat with random header fields and then nbeats data beats.
    // Data words lean toward the all-zero and all-one extremes now and then,
    // and about one word in ten is flagged as the checksum field.
    task automatic send_message(input icsum_pkg::t_kind k, input int tlen, input int nbeats);
        logic [15:0] w;
        send_beat(start_of(k, 16'(tlen), $urandom, $urandom, 8'($urandom)), 1'b1);
        repeat (nbeats) begin
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(1) ? 16'hffff : 16'h0000;
            end else begin
                w = 16'($urandom);
            end
            send_beat(word_of(w, $urandom_range(9) == 0), 1'b1);
        end
    endtask

    // Result side: ready is low in about a quarter of the cycles, except in
    // the calm window. Once, the hold-off below keeps it low for a counted
    // stretch while the sender keeps offering beats with no gaps.
    initial begin
        forever begin
            @(negedge clk);
            if (!held_once && beats_sent >= HOLD_AT_BEAT) begin
                held_once = 1'b1;
                holding   = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                holding   = 1'b0;
            end else if (calm_stretch()) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin : stimulus
        int               pick;
        int               tlen;
        int               need;
        int               nbeats;
        int               first_random;
        icsum_pkg::t_kind k;
        bit               msg_open;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty payloads: ICMP yields all ones, TCP covers only a
        // pseudo-header built from all-one fields.
        send_beat(start_of(icsum_pkg::KIND_ICMP, 16'd20, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        send_beat(start_of(icsum_pkg::KIND_TCP, 16'd20, 32'hffffffff, 32'hffffffff,
                           8'hff), 1'b1);
        // Total lengths shorter than the IP header, the smallest and the largest.
        send_beat(start_of(icsum_pkg::KIND_UDP, 16'd0, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        send_beat(start_of(icsum_pkg::KIND_IP, 16'd19, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        // A full IP header of all-one words with its checksum field flagged,
        // so the flagged word must count as zero.
        send_beat(start_of(icsum_pkg::KIND_IP, 16'd20, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        for (int i = 0; i < HDR_BYTES / 2; i++) begin
            send_beat(word_of((i == 5) ? 16'h1234 : 16'hffff, i == 5), 1'b1);
        end
        // A data beat with no message open is dropped.
        send_beat(word_of(16'hffff, 1'b0), 1'b0);
        // One-byte payload: the low half of the word is padded with zero.
        send_beat(start_of(icsum_pkg::KIND_UDP, 16'd21, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        send_beat(word_of(16'hffff, 1'b0), 1'b1);
        // Odd payload over two words with zero addresses and a zero protocol.
        send_beat(start_of(icsum_pkg::KIND_TCP, 16'd23, 32'h0, 32'h0, 8'h00), 1'b1);
        send_beat(word_of(16'hffff, 1'b0), 1'b1);
        send_beat(word_of(16'hffff, 1'b0), 1'b1);
        // A start in the middle of a message abandons the first one.
        send_beat(start_of(icsum_pkg::KIND_ICMP, 16'd30, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        send_beat(word_of(16'($urandom), 1'b0), 1'b1);
        send_beat(start_of(icsum_pkg::KIND_ICMP, 16'd22, $urandom, $urandom,
                           8'($urandom)), 1'b1);
        send_beat(word_of(16'($urandom), 1'b0), 1'b1);

        // Random part: mostly complete messages with small payloads, some
        // larger ones, and a share of short starts, broken messages (any
        // total length, often cut off early) and stray data beats.
        first_random = beats_sent;
        msg_open     = 1'b0;
        while (beats_sent - first_random < RANDOM_BEATS) begin
            pick = $urandom_range(99);
            k    = icsum_pkg::t_kind'($urandom_range(3));
            if (pick < 6) begin
                if (!msg_open) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_beat(word_of(16'($urandom), 1'($urandom)), 1'b0);
                    end
                end
            end else if (pick < 10) begin
                send_message(k, $urandom_range(HDR_BYTES - 1), 0);
                msg_open = 1'b0;
            end else if (pick < 22) begin
                tlen   = $urandom_range(1) ? $urandom_range(65535)
                                           : HDR_BYTES + $urandom_range(40);
                need   = beats_needed(k, tlen);
                nbeats = $urandom_range(need < 8 ? need : 8);
                send_message(k, tlen, nbeats);
                msg_open = nbeats < need;
            end else begin
                tlen = HDR_BYTES + (($urandom_range(4) == 0) ? $urandom_range(41, 300)
                                                            : $urandom_range(40));
                send_message(k, tlen, beats_needed(k, tlen));
                msg_open = 1'b0;
            end
        end

        // One message of the largest total length, cut off after a few
        // words: the byte count starts from the largest payload length.
        send_message(icsum_pkg::KIND_UDP, 65535, 4);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        // Wait longer so that a stray extra result would still show.
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: ip_icmp_tcp_udp_checksum_top.f
hdl/icsum_pkg.sv
hdl/icsum_in_stage.sv
hdl/icsum_engine.sv
hdl/ip_icmp_tcp_udp_checksum_top.sv
hdl/icsum_checker.sv
dv/icsum_checker.sv
dv/tb_top.sv
